// File: src/pafk_pkg.sv
// ============================================================================
// pafk_pkg: shared types and constants for the planar arm kinematics block
// Holds request codes, the CORDIC arctangent table and command and state types.
// ============================================================================
package pafk_pkg;

  localparam int unsigned NumLinksDefault    = 4;
  localparam int unsigned CordicItersDefault = 16;
  localparam int unsigned MaxLinks           = 6;
  localparam int unsigned NumRegs            = 7;
  localparam int unsigned RegStep            = 6;
  localparam logic [15:0] LenReset           = 16'd256;
  localparam logic [15:0] StepReset          = 16'd328;
  localparam logic [15:0] KGain              = 16'd39797;
  localparam logic signed [19:0] PosMax      = 20'sh7FFFF;
  localparam logic signed [19:0] PosMin      = -20'sh80000;

  typedef enum logic {
    REQ_SET    = 1'b0,
    REQ_ROTATE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    CMD_POSE = 2'd0,
    CMD_BAD  = 2'd1
  } cmd_e;

  // Command handed from the front to the back: pose walk or error report.
  typedef struct packed {
    cmd_e cmd;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_ITER,
    BK_ROUND,
    BK_EMIT
  } bk_state_e;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    begin
      r = 32'd0;
      case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: src/pafk_front.sv
// ============================================================================
// pafk_front: request decoder and angle state
// Classifies each transaction, updates staged and absolute angles and
// posts a command to the back end.
// ============================================================================
module pafk_front #(
  parameter int unsigned NumLinks = pafk_pkg::NumLinksDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        req_type_i,
  input  logic [2:0]  joint_index_i,
  input  logic [15:0] joint_angle_i,
  input  logic signed [1:0] rotate_dir_i,
  input  logic        set_last_i,
  input  logic [15:0] angle_step_i,
  input  logic        busy_i,
  output logic        cmd_valid_o,
  output pafk_pkg::cmd_t cmd_o,
  output logic [NumLinks*16-1:0] abs_angles_o
);

  logic [15:0] staged_q [NumLinks];
  logic [15:0] abs_q [NumLinks];
  logic        accept;
  logic [15:0] delta;
  logic [15:0] acc [NumLinks];
  logic        idx_ok;
  logic signed [17:0] prod;

  // The angle state must not move while the back end reads it.
  assign full_o = busy_i;
  assign accept = push_i && !busy_i;
  assign idx_ok = ({29'd0, joint_index_i} < NumLinks);
  assign prod   = $signed({2'b00, angle_step_i}) * rotate_dir_i;
  assign delta  = prod[15:0];

  always_comb begin
    for (int k = 0; k < NumLinks; k++) begin
      if (k == 0) acc[k] = ((joint_index_i == 3'(k)) ? joint_angle_i : staged_q[k]);
      else acc[k] = acc[k-1] + ((joint_index_i == 3'(k)) ? joint_angle_i : staged_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumLinks; k++) begin
        staged_q[k] <= '0;
        abs_q[k] <= '0;
      end
      cmd_valid_o <= 1'b0;
      cmd_o.cmd   <= pafk_pkg::CMD_POSE;
    end else begin
      cmd_valid_o <= 1'b0;
      if (accept) begin
        if (req_type_i == pafk_pkg::REQ_SET) begin
          for (int k = 0; k < NumLinks; k++) begin
            if (joint_index_i == 3'(k)) staged_q[k] <= joint_angle_i;
          end
          if (set_last_i) begin
            for (int k = 0; k < NumLinks; k++) abs_q[k] <= acc[k];
            cmd_valid_o <= 1'b1;
            cmd_o.cmd   <= pafk_pkg::CMD_POSE;
          end
        end else begin
          cmd_valid_o <= 1'b1;
          if (idx_ok) begin
            for (int k = 0; k < NumLinks; k++) begin
              if (3'(k) >= joint_index_i) abs_q[k] <= abs_q[k] + delta;
            end
            cmd_o.cmd <= pafk_pkg::CMD_POSE;
          end else begin
            cmd_o.cmd <= pafk_pkg::CMD_BAD;
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NumLinks; k++) abs_angles_o[k*16 +: 16] = abs_q[k];
  end

endmodule

// File: src/pafk_back.sv
// ============================================================================
// pafk_back: pose walker with a shared CORDIC and a result queue
// Walks the links one at a time, rotating each length by its angle and
// accumulating saturated base positions into a small output queue.
// ============================================================================
module pafk_back #(
  parameter int unsigned NumLinks    = pafk_pkg::NumLinksDefault,
  parameter int unsigned CordicIters = pafk_pkg::CordicItersDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  pafk_pkg::cmd_t cmd_i,
  input  logic [NumLinks*16-1:0] abs_angles_i,
  input  logic [pafk_pkg::MaxLinks*16-1:0] lens_i,
  output logic        busy_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  link_index_o,
  output logic signed [19:0] pos_x_o,
  output logic signed [19:0] pos_y_o,
  output logic [15:0] link_angle_o,
  output logic        status_o,
  output logic        last_o
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned ItW    = $clog2(CordicIters + 1);

  pafk_pkg::bk_state_e state_q, state_d;

  logic [2:0]  link_q;
  logic [ItW-1:0] it_q;
  logic signed [47:0] x_q, y_q;
  logic signed [33:0] z_q;
  logic        flip_q;
  logic signed [19:0] px_q, py_q;
  logic signed [31:0] cx_q, sy_q;

  // Result queue, two entries.
  logic [60:0] q_mem [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        q_push;
  logic [60:0] q_wdata;

  logic [15:0] ang, a_fold, len;
  logic        fold;
  logic signed [47:0] dx, dy;
  logic signed [33:0] at;
  logic signed [47:0] xr, yr;
  logic signed [31:0] cx, sy;
  logic signed [33:0] sx, sy2;
  logic signed [19:0] nx, ny;

  assign ang    = abs_angles_i[link_q*16 +: 16];
  assign len    = lens_i[link_q*16 +: 16];
  assign fold   = (ang[15:14] == 2'd1) || (ang[15:14] == 2'd2);
  assign a_fold = fold ? (ang ^ 16'h8000) : ang;
  assign dx     = y_q >>> it_q;
  assign dy     = x_q >>> it_q;
  assign at     = $signed({2'b00, pafk_pkg::atan_lut(5'(it_q))});
  assign xr     = (x_q + 48'sd32768) >>> 16;
  assign yr     = (y_q + 48'sd32768) >>> 16;
  assign cx     = flip_q ? -xr[31:0] : xr[31:0];
  assign sy     = flip_q ? -yr[31:0] : yr[31:0];
  assign sx     = {{14{px_q[19]}}, px_q} + {{2{cx_q[31]}}, cx_q};
  assign sy2    = {{14{py_q[19]}}, py_q} + {{2{sy_q[31]}}, sy_q};
  assign nx     = (sx > 34'sd524287) ? pafk_pkg::PosMax :
                  (sx < -34'sd524288) ? pafk_pkg::PosMin : sx[19:0];
  assign ny     = (sy2 > 34'sd524287) ? pafk_pkg::PosMax :
                  (sy2 < -34'sd524288) ? pafk_pkg::PosMin : sy2[19:0];

  always_comb begin
    state_d = state_q;
    q_push  = 1'b0;
    q_wdata = {link_q, px_q, py_q, ang, 1'b0,
               (link_q == 3'(NumLinks - 1))};
    unique case (state_q)
      pafk_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.cmd == pafk_pkg::CMD_BAD) state_d = pafk_pkg::BK_EMIT;
          else state_d = pafk_pkg::BK_LOAD;
        end
      end
      pafk_pkg::BK_LOAD:  state_d = pafk_pkg::BK_ITER;
      pafk_pkg::BK_ITER:  if (it_q == ItW'(CordicIters - 1)) state_d = pafk_pkg::BK_ROUND;
      pafk_pkg::BK_ROUND: state_d = pafk_pkg::BK_EMIT;
      pafk_pkg::BK_EMIT: begin
        if (cnt_q != 2'(QDepth)) begin
          q_push = 1'b1;
          if (flip_q && link_q == 3'd7) begin
            q_wdata = {3'd0, 20'sd0, 20'sd0, 16'd0, 1'b1, 1'b1};
            state_d = pafk_pkg::BK_IDLE;
          end else if (link_q == 3'(NumLinks - 1)) begin
            state_d = pafk_pkg::BK_IDLE;
          end else begin
            state_d = pafk_pkg::BK_LOAD;
          end
        end
      end
      default: state_d = pafk_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pafk_pkg::BK_IDLE;
      link_q  <= '0;
      it_q    <= '0;
      flip_q  <= 1'b0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        pafk_pkg::BK_IDLE: begin
          px_q <= '0;
          py_q <= '0;
          if (cmd_valid_i) begin
            // Link index 7 with flip marks the error report.
            link_q <= (cmd_i.cmd == pafk_pkg::CMD_BAD) ? 3'd7 : 3'd0;
            flip_q <= (cmd_i.cmd == pafk_pkg::CMD_BAD);
          end
        end
        pafk_pkg::BK_LOAD: begin
          it_q   <= '0;
          flip_q <= fold;
          x_q    <= $signed({32'd0, len}) * $signed({32'd0, pafk_pkg::KGain});
          y_q    <= '0;
          z_q    <= $signed({{2{a_fold[15]}}, a_fold, 16'd0});
        end
        pafk_pkg::BK_ITER: begin
          it_q <= it_q + 1'b1;
          if (!z_q[33]) begin
            x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
          end else begin
            x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
          end
        end
        pafk_pkg::BK_ROUND: begin
          cx_q <= cx;
          sy_q <= sy;
        end
        pafk_pkg::BK_EMIT: begin
          if (q_push && state_d == pafk_pkg::BK_LOAD) begin
            px_q   <= nx;
            py_q   <= ny;
            link_q <= link_q + 1'b1;
          end
        end
        default: ;
      endcase
      if (q_push) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, q_push} - {1'b0, (pop_i && !empty_o)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push) q_mem[wp_q] <= q_wdata;
  end

  assign busy_o  = (state_q != pafk_pkg::BK_IDLE) || cmd_valid_i;
  assign empty_o = (cnt_q == 2'd0);
  assign {link_index_o, pos_x_o, pos_y_o, link_angle_o, status_o, last_o} = q_mem[rp_q];

endmodule

// File: src/pafk_cfg.sv
// ============================================================================
// pafk_cfg: configuration register file
// Holds link lengths and the rotation step behind an APB-style port.
// ============================================================================
module pafk_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [pafk_pkg::MaxLinks*16-1:0] lens_o,
  output logic [15:0] step_o
);

  logic [15:0] regs_q [pafk_pkg::NumRegs];
  logic [2:0]  idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pafk_pkg::MaxLinks; i++) regs_q[i] <= pafk_pkg::LenReset;
      regs_q[pafk_pkg::RegStep] <= pafk_pkg::StepReset;
    end else if (psel && penable && pwrite && ({29'd0, idx} < pafk_pkg::NumRegs)) begin
      regs_q[idx] <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if ({29'd0, idx} < pafk_pkg::NumRegs) prdata = {16'd0, regs_q[idx]};
    for (int i = 0; i < pafk_pkg::MaxLinks; i++) lens_o[i*16 +: 16] = regs_q[i];
  end

  assign step_o = regs_q[pafk_pkg::RegStep];

endmodule

// File: src/planar_arm_forward_kinematics.sv
// ============================================================================
// planar_arm_forward_kinematics: forward kinematics of a planar serial arm
// Keeps joint angles and reports the base pose of every link after updates.
// ============================================================================
// Input transactions arrive on push/full: a set request stages one
// relative joint angle, and the set marked last recomputes all absolute
// angles; a rotate request turns a link and all links after it by the
// configured step. Results leave on empty/pop, one per link with its
// base x, y and absolute angle, the last one flagged. A rotate with a bad
// index gives a single result with status set.
// The front end updates the angle state and posts a command.
// The back end walks the links through one shared CORDIC: a load step,
// CordicIters iteration steps, a rounding step and an emit step per
// link. A set without the last flag starts no walk. full stays high
// while a walk runs.
// A two-entry result queue decouples the walk from the receiver: when the
// receiver stalls the walk holds in its emit cycle.
// Reset clears all angles to zero and loads the default lengths and step.
// ============================================================================
module planar_arm_forward_kinematics #(
  parameter int unsigned NumLinks    = pafk_pkg::NumLinksDefault,
  parameter int unsigned CordicIters = pafk_pkg::CordicItersDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [2:0]  joint_index_i,
  input  logic [15:0] joint_angle_i,
  input  logic signed [1:0] rotate_dir_i,
  input  logic        set_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  link_index_o,
  output logic signed [19:0] pos_x_o,
  output logic signed [19:0] pos_y_o,
  output logic [15:0] link_angle_o,
  output logic        status_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [pafk_pkg::MaxLinks*16-1:0] lens;
  logic [15:0] step;
  logic        busy;
  logic        cmd_valid;
  pafk_pkg::cmd_t cmd;
  logic [NumLinks*16-1:0] abs_angles;

  pafk_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .lens_o(lens), .step_o(step)
  );

  pafk_front #(.NumLinks(NumLinks)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_type_i, .joint_index_i,
    .joint_angle_i, .rotate_dir_i, .set_last_i, .angle_step_i(step),
    .busy_i(busy), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .abs_angles_o(abs_angles)
  );

  pafk_back #(.NumLinks(NumLinks), .CordicIters(CordicIters)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .abs_angles_i(abs_angles),
    .lens_i(lens), .busy_o(busy), .empty_o(empty), .pop_i(pop),
    .link_index_o, .pos_x_o, .pos_y_o, .link_angle_o, .status_o, .last_o
  );

  // A command is posted only for an accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid |-> $past(push && !full))
    else $error("command without accepted transaction");

  // An error report is always a single final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> last_o)
    else $error("error result not marked last");

  // The front end is closed while it posts a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid |-> full)
    else $error("input open while command pending");

endmodule

// File: tb/testbench.sv
// ============================================================================
// testbench: self-checking bench for the planar arm forward kinematics block
// Drives set and rotate requests, predicts every link pose with a CORDIC
// model of its own and compares each popped result field by field.
// ============================================================================
module testbench;

  localparam int unsigned NLinks    = 4;
  localparam int unsigned NIters    = 16;
  localparam int unsigned RandItems = 500;
  localparam int unsigned SettleCyc = 120;
  localparam int unsigned LongHold  = 400;
  localparam longint      CycLimit  = 600000;

  // Register indexes; byte address is four times the index.
  typedef enum int {
    REG_LEN0 = 0, REG_LEN1 = 1, REG_LEN2 = 2, REG_LEN3 = 3,
    REG_LEN4 = 4, REG_LEN5 = 5, REG_STEP = 6
  } reg_idx_e;

  typedef struct packed {
    pafk_pkg::req_e kind;
    logic [2:0]  idx;
    logic [15:0] ang;
    logic [1:0]  dir;
    logic        lst;
  } request_t;

  typedef struct packed {
    logic [2:0]         link;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic [15:0]        ang;
    logic               stat;
    logic               lst;
  } pose_t;

  // One row of the directed table: a request, and optionally a pose that is
  // known by inspection and must match the prediction for the first link.
  typedef struct {
    request_t req;
    bit       has_known;
    pose_t    known;
  } row_t;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  logic req_type_i, set_last_i;
  logic [2:0] joint_index_i;
  logic [15:0] joint_angle_i;
  logic signed [1:0] rotate_dir_i;
  logic [2:0] link_index_o;
  logic signed [19:0] pos_x_o, pos_y_o;
  logic [15:0] link_angle_o;
  logic status_o, last_o;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  planar_arm_forward_kinematics uut (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .joint_index_i,
    .joint_angle_i, .rotate_dir_i, .set_last_i, .empty, .pop,
    .link_index_o, .pos_x_o, .pos_y_o, .link_angle_o, .status_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state: lengths, step, staged relative and absolute angles.
  logic [15:0] len_q [6];
  logic [15:0] step_q;
  logic [15:0] rel_q [NLinks];
  logic [15:0] abs_q [NLinks];
  pose_t       pose_queue [$];

  int  err_count;
  bit  hold_rx;
  bit  long_hold_req;
  longint cyc;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is cut off if it hangs; this is the only other way out.
  initial begin
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > CycLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, exp, cyc);
    err_count++;
  endtask

  function automatic longint shr(input longint v, input int s);
    return v >>> s;
  endfunction

  // Length times cos and sin of an angle via a CORDIC in Q47.16.
  task automatic rotate_vector(input logic [15:0] len, input logic [15:0] a,
                               output longint cx, output longint sy);
    logic [1:0]  q;
    bit          flip;
    logic [15:0] af;
    longint      x, y, z, dx, dy;
    q    = a[15:14];
    flip = (q == 2'd1) || (q == 2'd2);
    af   = flip ? (a ^ 16'h8000) : a;
    z    = longint'($signed(af)) * 65536;
    x    = longint'(len) * longint'(pafk_pkg::KGain);
    y    = 0;
    for (int i = 0; i < NIters; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(pafk_pkg::atan_lut(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(pafk_pkg::atan_lut(5'(i)));
      end
    end
    x  = shr(x + 32768, 16);
    y  = shr(y + 32768, 16);
    cx = flip ? -x : x;
    sy = flip ? -y : y;
  endtask

  function automatic longint clamp_pos(input longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  task automatic queue_pose_walk();
    longint px, py, cx, sy;
    pose_t  p;
    px = 0;
    py = 0;
    for (int k = 0; k < NLinks; k++) begin
      p.link = 3'(k);
      p.px   = 20'(px);
      p.py   = 20'(py);
      p.ang  = abs_q[k];
      p.stat = 1'b0;
      p.lst  = (k == NLinks - 1);
      pose_queue.push_back(p);
      rotate_vector(len_q[k], abs_q[k], cx, sy);
      px = clamp_pos(px + cx);
      py = clamp_pos(py + sy);
    end
  endtask

  // Updates the predicted state for one accepted request and queues poses.
  task automatic predict_arm(input request_t r);
    logic [15:0] acc, delta;
    int          d;
    pose_t       p;
    if (r.kind == pafk_pkg::REQ_SET) begin
      if (r.idx < NLinks) rel_q[r.idx] = r.ang;
      if (r.lst) begin
        acc = 16'd0;
        for (int k = 0; k < NLinks; k++) begin
          acc      = acc + rel_q[k];
          abs_q[k] = acc;
        end
        queue_pose_walk();
      end
    end else if (r.idx >= NLinks) begin
      p = '0;
      p.stat = 1'b1;
      p.lst  = 1'b1;
      pose_queue.push_back(p);
    end else begin
      d     = $signed(r.dir);
      delta = 16'(int'(step_q) * d);
      for (int k = r.idx; k < NLinks; k++) abs_q[k] = abs_q[k] + delta;
      queue_pose_walk();
    end
  endtask

  // Setup and access cycle of one write; the caller closes the port after
  // the last write of a group.
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_STEP) step_q = val;
    else len_q[idx] = val;
  endtask

  // Offers one request and waits until the block takes it. push stays high
  // after acceptance so that a request with no gap follows directly.
  task automatic send_request(input request_t r, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    req_type_i    <= r.kind;
    joint_index_i <= r.idx;
    joint_angle_i <= r.ang;
    rotate_dir_i  <= r.dir;
    set_last_i    <= r.lst;
    do @(posedge clk_i); while (full);
    predict_arm(r);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  function automatic request_t random_request();
    request_t r;
    int       pick;
    r.ang = 16'($urandom);
    r.dir = 2'($urandom);
    r.lst = 1'($urandom);
    pick  = $urandom_range(0, 99);
    if (pick < 45) begin
      r.kind = pafk_pkg::REQ_SET;
      r.idx  = 3'($urandom_range(0, NLinks - 1));
      r.lst  = ($urandom_range(0, 3) == 0);
    end else if (pick < 52) begin
      r.kind = pafk_pkg::REQ_SET;
      r.idx  = 3'($urandom_range(NLinks, 7));
    end else if (pick < 92) begin
      r.kind = pafk_pkg::REQ_ROTATE;
      r.idx  = 3'($urandom_range(0, NLinks - 1));
    end else begin
      r.kind = pafk_pkg::REQ_ROTATE;
      r.idx  = 3'($urandom_range(NLinks, 7));
    end
    return r;
  endfunction

  // Receiver: pops with random stalls, or a long hold when asked, and checks.
  initial begin
    pose_t e;
    int    stall;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        pop <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      stall = hold_rx ? $urandom_range(0, 13) : 0;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      pop <= 1'b0;
      if (pose_queue.size() == 0) begin
        report("unexpected result", link_index_o, 0);
      end else begin
        e = pose_queue.pop_front();
        if (link_index_o !== e.link) report("link_index", link_index_o, e.link);
        if (pos_x_o !== e.px)        report("pos_x", pos_x_o, e.px);
        if (pos_y_o !== e.py)        report("pos_y", pos_y_o, e.py);
        if (link_angle_o !== e.ang)  report("link_angle", link_angle_o, e.ang);
        if (status_o !== e.stat)     report("status", status_o, e.stat);
        if (last_o !== e.lst)        report("last", last_o, e.lst);
      end
    end
  end

  row_t directed [$];

  function automatic row_t mk(input pafk_pkg::req_e k, input int i, input int a,
                              input int d, input bit l);
    row_t w;
    w.req       = '{kind: k, idx: 3'(i), ang: 16'(a), dir: 2'(d), lst: l};
    w.has_known = 1'b0;
    w.known     = '0;
    return w;
  endfunction

  initial begin
    row_t    w;
    pose_t   kp;
    request_t r;
    int       lens [4];
    err_count = 0;
    hold_rx = 1'b1;
    long_hold_req = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    req_type_i = 1'b0;
    joint_index_i = '0;
    joint_angle_i = '0;
    rotate_dir_i = '0;
    set_last_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < 6; i++) len_q[i] = pafk_pkg::LenReset;
    step_q = pafk_pkg::StepReset;
    for (int k = 0; k < NLinks; k++) begin
      rel_q[k] = '0;
      abs_q[k] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. The first row reports the reset pose: link 0 at the
    // origin with angle zero. A bad rotate index yields a zeroed pose with status and last set.
    w = mk(pafk_pkg::REQ_SET, 0, 0, 0, 1'b1);
    w.has_known = 1'b1;
    w.known = '{link: 3'd0, px: '0, py: '0, ang: 16'd0, stat: 1'b0, lst: 1'b0};
    directed.push_back(w);
    w = mk(pafk_pkg::REQ_ROTATE, 4, 0, 1, 1'b0);
    w.has_known = 1'b1;
    w.known = '{link: 3'd0, px: '0, py: '0, ang: 16'd0, stat: 1'b1, lst: 1'b1};
    directed.push_back(w);
    w = mk(pafk_pkg::REQ_ROTATE, 7, 16'hFFFF, 2, 1'b1);
    w.has_known = 1'b1;
    w.known = '{link: 3'd0, px: '0, py: '0, ang: 16'd0, stat: 1'b1, lst: 1'b1};
    directed.push_back(w);
    directed.push_back(mk(pafk_pkg::REQ_SET, 0, 16'hFFFF, 0, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_SET, 1, 16'h4000, 0, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_SET, 2, 16'h8000, 0, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_SET, 3, 16'hC000, 0, 1'b1));
    directed.push_back(mk(pafk_pkg::REQ_SET, 5, 16'h1234, 0, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_SET, 6, 16'h5555, 0, 1'b1));
    directed.push_back(mk(pafk_pkg::REQ_ROTATE, 0, 0, 1, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_ROTATE, 1, 0, -1, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_ROTATE, 2, 0, 0, 1'b1));
    directed.push_back(mk(pafk_pkg::REQ_ROTATE, 3, 16'hAAAA, -2, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_SET, 0, 16'h3FFF, 3, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_SET, 1, 16'h7FFF, 1, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_SET, 2, 16'h8001, 2, 1'b0));
    directed.push_back(mk(pafk_pkg::REQ_SET, 3, 16'hBFFF, 0, 1'b1));

    foreach (directed[i]) begin
      if (directed[i].has_known) begin
        kp = directed[i].known;
        // Check that a known pose for a set row starts at x zero before sending.
        r = directed[i].req;
        if (r.kind == pafk_pkg::REQ_SET && kp.px !== 20'sd0) report("table", kp.px, 0);
      end
      send_request(directed[i].req, 1'b1);
      if (directed[i].has_known && pose_queue.size() != 0) begin
        kp = pose_queue[pose_queue.size() -
                        (directed[i].req.kind == pafk_pkg::REQ_SET ? NLinks : 1)];
        if (kp !== directed[i].known) report("known pose", kp, directed[i].known);
      end
    end
    drain_results();

    // Extreme lengths and steps, then walk random settings. Each phase is
    // written while the block is idle with nothing outstanding.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: lens = '{65535, 65535, 65535, 65535};
        1: lens = '{0, 0, 0, 0};
        default: foreach (lens[j]) lens[j] = $urandom_range(0, 65535);
      endcase
      write_reg(REG_LEN0, 16'(lens[0]));
      write_reg(REG_LEN1, 16'(lens[1]));
      write_reg(REG_LEN2, 16'(lens[2]));
      write_reg(REG_LEN3, 16'(lens[3]));
      write_reg(REG_LEN4, 16'($urandom));
      write_reg(REG_LEN5, 16'($urandom));
      write_reg(REG_STEP, phase == 0 ? 16'hFFFF : (phase == 1 ? 16'h0000 : 16'($urandom)));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (phase == 2) long_hold_req = 1'b1;
      for (int n = 0; n < RandItems / 5; n++) send_request(random_request(), hold_rx);
      drain_results();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
src/pafk_pkg.sv
src/pafk_front.sv
src/pafk_back.sv
src/pafk_cfg.sv
src/planar_arm_forward_kinematics.sv
tb/testbench.sv
